>>> rtl/fdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and constants of the first duplicate detector
// store depth, counter width, sequencer states and cell control
// ----------------------------------------------------------------------------
package fdd_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef logic signed [VAL_W-1:0] fdd_value_t;
    typedef logic [CNT_W-1:0]        fdd_count_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DECIDE
    } fdd_state_t;

    typedef struct packed {
        logic shift_en;
        logic cmp_en;
    } fdd_cell_ctrl_t;

endpackage

>>> rtl/fdd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd channel interfaces: valid/ready channels for input items and results
// one transaction moves when valid and ready are both high at a clock edge
// ----------------------------------------------------------------------------
interface fdd_in_if import fdd_pkg::*;;
    logic       valid;
    logic       ready;
    fdd_value_t value_in;
    logic       set_last;

    modport source (output valid, output value_in, output set_last, input ready);
    modport sink   (input valid, input value_in, input set_last, output ready);
endinterface

interface fdd_out_if import fdd_pkg::*;;
    logic       valid;
    logic       ready;
    logic       found;
    fdd_value_t repeat_value;
    logic       overflowed;

    modport source (output valid, output found, output repeat_value, output overflowed,
                    input ready);
    modport sink   (input valid, input found, input repeat_value, input overflowed,
                    output ready);
endinterface

>>> rtl/fdd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_cell: one entry of the value chain
// holds a stored value, shifts it to its right neighbor on insert and
// registers a match of the broadcast query
// ----------------------------------------------------------------------------
module fdd_cell
    import fdd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  fdd_cell_ctrl_t ctrl,
    input  logic           cell_valid,
    input  fdd_value_t     query,
    input  fdd_value_t     prev_value,
    output fdd_value_t     held_value,
    output logic           hit
);

    fdd_value_t held_reg;
    logic       hit_reg;
    logic       hit_next;

    assign hit_next = ctrl.cmp_en ? (cell_valid && (held_reg == query)) : hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            held_reg <= prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign held_value = held_reg;
    assign hit        = hit_reg;

endmodule

>>> rtl/first_duplicate_detector.sv
`timescale 1ns / 1ps
// sequence: an item is compared in the cycle after its transaction, in the compare state; the
// decide state then loads any result into the output register, holding while the slot is full
// items: a new item is taken only in the idle state, so each one passes the accept, compare and
// decide (match reduction and update) states; an item after a reported repeat is dropped in idle
// reset: sequencer, fill count, flags and output valid clear at once; no clearing pass
// ----------------------------------------------------------------------------
// first_duplicate_detector: first repeated value of each set
// a chain of cells holds the distinct values of the set, every cell compares
// the query in parallel, new values shift in at the head of the chain
// ----------------------------------------------------------------------------
module first_duplicate_detector
    import fdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    fdd_in_if.sink    items,
    fdd_out_if.source results
);

    fdd_state_t     state_reg, state_next;
    fdd_count_t     count_reg, count_next;
    logic           done_reg, done_next;
    logic           ovf_reg, ovf_next;
    fdd_value_t     query_reg;
    logic           last_reg;

    logic           out_valid_reg, out_valid_next;
    logic           out_found_reg;
    fdd_value_t     out_value_reg;
    logic           out_ovf_reg;

    fdd_cell_ctrl_t cell_ctrl;
    fdd_value_t     held [CAPACITY];
    logic [CAPACITY-1:0] hits;

    logic           accept;
    logic           any_hit;
    logic           need_emit;
    logic           slot_busy;
    logic           emit;
    logic           emit_found;
    logic           emit_ovf;
    logic           insert;
    logic           stall;

    assign accept    = items.valid && items.ready;
    assign any_hit   = |hits;
    assign slot_busy = out_valid_reg && !results.ready;
    assign need_emit = any_hit || last_reg;
    assign stall     = need_emit && slot_busy;

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            fdd_value_t prev;
            logic       valid_entry;

            if (gi == 0)
            begin : g_head
                assign prev = query_reg;
            end
            else
            begin : g_body
                assign prev = held[gi-1];
            end

            assign valid_entry = (CNT_W'(gi) < count_reg);

            fdd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .cell_valid (valid_entry),
                .query      (query_reg),
                .prev_value (prev),
                .held_value (held[gi]),
                .hit        (hits[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !done_reg)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and set bookkeeping
    always_comb
    begin
        items.ready    = 1'b0;
        cell_ctrl      = '0;
        count_next     = count_reg;
        done_next      = done_reg;
        ovf_next       = ovf_reg;
        emit           = 1'b0;
        emit_found     = 1'b0;
        emit_ovf       = ovf_reg;
        insert         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
                if (accept && done_reg && items.set_last)
                begin
                    count_next = '0;
                    done_next  = 1'b0;
                    ovf_next   = 1'b0;
                end
            end
            ST_CMP:
            begin
                cell_ctrl.cmp_en = 1'b1;
            end
            ST_DECIDE:
            begin
                if (!stall)
                begin
                    if (any_hit)
                    begin
                        emit       = 1'b1;
                        emit_found = 1'b1;
                        done_next  = !last_reg;
                    end
                    else
                    begin
                        if (count_reg < CNT_W'(CAPACITY))
                        begin
                            insert     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                            emit_ovf = 1'b1;
                        end
                        emit = last_reg;
                    end
                    if (last_reg)
                    begin
                        count_next = '0;
                        done_next  = 1'b0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                items.ready = 1'b0;
            end
        endcase
        cell_ctrl.shift_en = insert;
    end

    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= items.value_in;
            last_reg  <= items.set_last;
        end
        if (emit)
        begin
            out_found_reg <= emit_found;
            out_value_reg <= emit_found ? query_reg : '0;
            out_ovf_reg   <= emit_ovf;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.found        = out_found_reg;
    assign results.repeat_value = out_value_reg;
    assign results.overflowed   = out_ovf_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("overflow flagged with free entries");

    a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (count_reg != '0))
        else $error("repeat reported on an empty store");

    a_cmp_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |=> (state_reg == ST_DECIDE))
        else $error("compare not followed by decide");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_value_reg == '0))
        else $error("not found result with nonzero value");

endmodule

>>> verif/first_duplicate_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_duplicate_detector_tb: self-checking testbench of the duplicate detector
// drives sets of signed values through the item channel, tracks the store of
// each set in a local predictor and compares every result field by field,
// under phases of sender gaps, receiver stalls and one long output hold-off
// ----------------------------------------------------------------------------
module first_duplicate_detector_tb
    import fdd_pkg::*;
;

    localparam int HOLD_CYCLES = 500;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 310;

    typedef struct packed {
        fdd_value_t value;
        logic       last;
    } set_item_t;

    typedef struct packed {
        logic       found;
        fdd_value_t repeat_value;
        logic       overflowed;
    } dup_result_t;

    logic clk;
    logic rst_n;

    fdd_in_if  items_if ();
    fdd_out_if results_if ();

    first_duplicate_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    set_item_t   item_q[$];
    dup_result_t expected_dups[$];

    fdd_value_t seen_tbl[CAPACITY];
    int         seen_cnt;
    bit         rep_reported;
    bit         lost_flag;

    int items_queued;
    int items_taken;
    int err_cnt;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_seq;
    int hold_seen;
    int hold_left;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void start_new_set();
        seen_cnt     = 0;
        rep_reported = 1'b0;
        lost_flag    = 1'b0;
    endfunction

    function automatic bit predict_dup(input fdd_value_t v, input logic last,
                                       output dup_result_t r);
        bit hit;
        hit = 1'b0;
        r   = '0;
        if (rep_reported)
        begin
            if (last)
                start_new_set();
            return 1'b0;
        end
        for (int i = 0; i < seen_cnt; i++)
            if (seen_tbl[i] == v)
                hit = 1'b1;
        if (hit)
        begin
            r.found        = 1'b1;
            r.repeat_value = v;
            r.overflowed   = lost_flag;
            if (last)
                start_new_set();
            else
                rep_reported = 1'b1;
            return 1'b1;
        end
        if (seen_cnt < CAPACITY)
        begin
            seen_tbl[seen_cnt] = v;
            seen_cnt++;
        end
        else
            lost_flag = 1'b1;
        if (last)
        begin
            r.overflowed = lost_flag;
            start_new_set();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic fdd_value_t pick_value();
        case ($urandom_range(19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input fdd_value_t v, input logic last);
        item_q.push_back('{value: v, last: last});
        items_queued++;
    endtask

    task automatic queue_long_set();
        fdd_value_t vals[$];
        int         n;
        int         tail;
        n    = $urandom_range(CAPACITY - 2, CAPACITY + 6);
        tail = $urandom_range(2);
        for (int i = 0; i < n; i++)
        begin
            vals.push_back($urandom);
            queue_item(vals[i], 1'b0);
        end
        case (tail)
            0: queue_item($urandom, 1'b1);
            1: queue_item(vals[$urandom_range(n - 1)], 1'b1);
            default:
            begin
                queue_item(vals[$urandom_range(n - 1)], 1'b0);
                queue_item($urandom, 1'b0);
                queue_item($urandom, 1'b1);
            end
        endcase
    endtask

    task automatic queue_short_set();
        fdd_value_t pool[8];
        int         len;
        int         psize;
        len   = $urandom_range(1, 10);
        psize = (len + 2 > 8) ? 8 : len + 2;
        psize = $urandom_range(1, psize);
        for (int i = 0; i < psize; i++)
            pool[i] = pick_value();
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(3) == 0)
                queue_item(pick_value(), i == len - 1);
            else
                queue_item(pool[$urandom_range(psize - 1)], i == len - 1);
        end
    endtask

    task automatic queue_phase(input int count);
        int target;
        target = items_queued + count;
        while (items_queued < target)
        begin
            if ($urandom_range(99) < 6)
                queue_long_set();
            else
                queue_short_set();
        end
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued)
            @(posedge clk);
        while (expected_dups.size() != 0)
            @(posedge clk);
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        set_item_t nxt;
        if (!rst_n)
        begin
            items_if.valid    <= 1'b0;
            items_if.value_in <= '0;
            items_if.set_last <= 1'b0;
        end
        else if (!items_if.valid || items_if.ready)
        begin
            if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = item_q.pop_front();
                items_if.valid    <= 1'b1;
                items_if.value_in <= nxt.value;
                items_if.set_last <= nxt.last;
            end
            else
                items_if.valid <= 1'b0;
        end
    end

    // result receiver, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // accepted item transaction: predict
    always @(posedge clk)
    begin : watch_items
        dup_result_t r;
        if (rst_n && items_if.valid && items_if.ready)
        begin
            if (predict_dup(items_if.value_in, items_if.set_last, r))
                expected_dups.push_back(r);
            items_taken++;
        end
    end

    // accepted result transaction: check
    always @(posedge clk)
    begin : watch_results
        dup_result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_dups.size() == 0)
            begin
                $error("unexpected result: found=%0b repeat_value=%h overflowed=%0b",
                       results_if.found, results_if.repeat_value, results_if.overflowed);
                err_cnt++;
            end
            else
            begin
                want = expected_dups.pop_front();
                if (results_if.found !== want.found)
                begin
                    $error("found: expected %0b, actual %0b", want.found, results_if.found);
                    err_cnt++;
                end
                if (results_if.repeat_value !== want.repeat_value)
                begin
                    $error("repeat_value: expected %h, actual %h",
                           want.repeat_value, results_if.repeat_value);
                    err_cnt++;
                end
                if (results_if.overflowed !== want.overflowed)
                begin
                    $error("overflowed: expected %0b, actual %0b",
                           want.overflowed, results_if.overflowed);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        items_if.valid    = 1'b0;
        items_if.value_in = '0;
        items_if.set_last = 1'b0;
        results_if.ready  = 1'b0;
        rst_n          = 1'b0;
        items_queued   = 0;
        items_taken    = 0;
        err_cnt        = 0;
        quiet_cycles   = 0;
        hold_seq       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        start_new_set();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // single item, no repeat
        queue_item(32'sh7fff_ffff, 1'b1);
        // repeat on the last item
        queue_item(32'sh8000_0000, 1'b0);
        queue_item(32'sh8000_0000, 1'b1);
        // repeat mid-set, the rest dropped
        queue_item(32'sd0, 1'b0);
        queue_item(-32'sd1, 1'b0);
        queue_item(32'sd0, 1'b0);
        queue_item(32'sd5, 1'b0);
        queue_item(32'sd6, 1'b1);
        // distinct values, some pairs differ in one bit only, no repeat
        queue_item(-32'sd1, 1'b0);
        queue_item(32'sh7fff_ffff, 1'b0);
        queue_item(32'sh8000_0000, 1'b0);
        queue_item(32'sd1, 1'b0);
        queue_item(-32'sd2, 1'b0);
        queue_item(32'sd0, 1'b1);
        // first repeat wins, the last item is dropped
        queue_item(32'sd1, 1'b0);
        queue_item(32'sd2, 1'b0);
        queue_item(32'sd3, 1'b0);
        queue_item(32'sd2, 1'b0);
        queue_item(32'sd1, 1'b1);
        // repeated value after a reported repeat
        queue_item(32'sd9, 1'b0);
        queue_item(32'sd9, 1'b0);
        queue_item(32'sd9, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            if (phase == 0)
                queue_long_set();
            if (phase == 2)
                hold_seq++;
            queue_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
